@@ rtl/hevc_sei_message_parser_macros.svh @@
// Assertion helpers for the SEI parser
`ifndef HEVC_SEI_MESSAGE_PARSER_MACROS_SVH
`define HEVC_SEI_MESSAGE_PARSER_MACROS_SVH

// Implication checked on every rising clock edge outside reset
`define SEI_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication outside reset
`define SEI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sei_pkg.sv @@
package sei_pkg;

    localparam int COUNT_BITS = 32;

    // Parse phases, numbered like the field codes
    localparam logic [4:0] PH_TYPE    = 5'd0;
    localparam logic [4:0] PH_SIZE    = 5'd1;
    localparam logic [4:0] PH_CC      = 5'd2;
    localparam logic [4:0] PH_EXT     = 5'd3;
    localparam logic [4:0] PH_T35     = 5'd4;
    localparam logic [4:0] PH_UUID_HI = 5'd5;
    localparam logic [4:0] PH_UUID_LO = 5'd6;
    localparam logic [4:0] PH_UNREG   = 5'd7;
    localparam logic [4:0] PH_PRIM_X  = 5'd8;
    localparam logic [4:0] PH_PRIM_Y  = 5'd9;
    localparam logic [4:0] PH_WHITE_X = 5'd10;
    localparam logic [4:0] PH_WHITE_Y = 5'd11;
    localparam logic [4:0] PH_MAX_LUM = 5'd12;
    localparam logic [4:0] PH_MIN_LUM = 5'd13;
    localparam logic [4:0] PH_LIGHT   = 5'd14;
    localparam logic [4:0] PH_PALL    = 5'd15;
    localparam logic [4:0] PH_ACANCEL = 5'd16;
    localparam logic [4:0] PH_USE_IDC = 5'd17;
    localparam logic [4:0] PH_BDEPTH  = 5'd18;
    localparam logic [4:0] PH_TRANSP  = 5'd19;
    localparam logic [4:0] PH_OPAQUE  = 5'd20;
    localparam logic [4:0] PH_CLIP    = 5'd22;
    localparam logic [4:0] PH_CLIPTYP = 5'd23;
    localparam logic [4:0] PH_RAW     = 5'd24;
    localparam logic [4:0] PH_WAIT    = 5'd25;

    localparam logic [1:0] ERR_OK        = 2'd0;
    localparam logic [1:0] ERR_HDR_TRUNC = 2'd1;
    localparam logic [1:0] ERR_SIZE      = 2'd2;
    localparam logic [1:0] ERR_PAY_TRUNC = 2'd3;

    localparam logic [7:0] BYTE_EXT = 8'hff;
    localparam logic [7:0] BYTE_EPB = 8'h03;

    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam int OQDEPTH = 8;
    localparam int OQAW    = 3;

    // Byte handed from the front part to the parser
    typedef struct packed {
        logic [7:0] data;
        logic       keep;
        logic       eob;
    } t_byte_item;

    typedef struct packed {
        logic [4:0]  code;
        logic [31:0] index;
        logic [63:0] value;
        logic [1:0]  err;
        logic        last;
    } t_result;

    // Field width of a bit-reader phase
    function automatic logic [6:0] field_width(input logic [4:0] ph, input logic [2:0] ad);
        unique case (ph)
            PH_UUID_HI, PH_UUID_LO:           field_width = 7'd64;
            PH_MAX_LUM, PH_MIN_LUM:           field_width = 7'd32;
            PH_PRIM_X, PH_PRIM_Y, PH_WHITE_X, PH_WHITE_Y,
            PH_LIGHT, PH_PALL:                field_width = 7'd16;
            PH_USE_IDC, PH_BDEPTH:            field_width = 7'd3;
            PH_TRANSP, PH_OPAQUE:             field_width = {4'd0, ad} + 7'd9;
            default:                          field_width = 7'd1;
        endcase
    endfunction

    function automatic logic is_bit_phase(input logic [4:0] ph);
        is_bit_phase = (ph == PH_UUID_HI) || (ph == PH_UUID_LO) ||
                       (ph >= PH_PRIM_X && ph <= PH_CLIPTYP);
    endfunction

endpackage

@@ rtl/sei_stream_if.sv @@
interface sei_stream_if #(parameter int W = 9);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/sei_front.sv @@
// Front part: accepts bytes, tracks the zero run and marks emulation bytes
module sei_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_strip,
    sei_stream_if.sink          in_if,
    output logic                o_push,
    output sei_pkg::t_byte_item o_item,
    input  logic                i_full
);
    logic [1:0] r_zero_run, n_zero_run;
    logic [7:0] w_b;
    logic       w_eob, w_drop;

    assign w_b   = in_if.payload[7:0];
    assign w_eob = in_if.payload[8];
    assign in_if.ready = !i_full;
    assign o_push = in_if.valid && !i_full;
    assign w_drop = i_strip && (r_zero_run == 2'd2) && (w_b == sei_pkg::BYTE_EPB);
    assign o_item = '{data: w_b, keep: !w_drop, eob: w_eob};

    // zero run, cleared on drops and at buffer end
    always_comb begin
        n_zero_run = r_zero_run;
        if (o_push) begin
            if (w_eob || w_drop) n_zero_run = 2'd0;
            else if (w_b == 8'd0) n_zero_run = (r_zero_run == 2'd2) ? 2'd2 : r_zero_run + 2'd1;
            else n_zero_run = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_zero_run <= 2'd0;
        else r_zero_run <= n_zero_run;
    end
endmodule

@@ rtl/sei_queue.sv @@
// Small byte queue between the front and the parser
module sei_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  sei_pkg::t_byte_item i_item,
    output logic                o_full,
    input  logic                i_pop,
    output logic                o_valid,
    output sei_pkg::t_byte_item o_item
);
    sei_pkg::t_byte_item r_mem [sei_pkg::QDEPTH];
    logic [sei_pkg::QAW-1:0] r_wp, r_rp;
    logic [sei_pkg::QAW:0]   r_cnt;

    assign o_full  = (r_cnt == sei_pkg::QAW'(0) + (sei_pkg::QAW+1)'(sei_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_item;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (sei_pkg::QAW+1)'(i_push) - (sei_pkg::QAW+1)'(i_pop);
        end
    end
endmodule

@@ rtl/sei_parser.sv @@
// Back part: parses one byte per cycle while a byte waits and the output queue
// has room for four results, and pushes up to four results into it.
`include "hevc_sei_message_parser_macros.svh"
module sei_parser (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  sei_pkg::t_byte_item i_item,
    output logic                o_pop,
    sei_stream_if.source        out_if
);
    // saturation limit of the type and size sums
    localparam logic [31:0] TOP = 32'((64'd1 << sei_pkg::COUNT_BITS) - 64'd1);

    logic [4:0]  r_ph;
    logic [31:0] r_type, r_size, r_left;
    logic [63:0] r_gath;
    logic [6:0]  r_held;
    logic [2:0]  r_ad, r_ec;

    logic [4:0]  n_ph;
    logic [31:0] n_type, n_size, n_left;
    logic [63:0] n_gath;
    logic [6:0]  n_held;
    logic [2:0]  n_ad, n_ec;

    sei_pkg::t_result w_res [4];
    logic [2:0] w_n;

    // output queue
    sei_pkg::t_result r_oq [sei_pkg::OQDEPTH];
    logic [sei_pkg::OQAW-1:0] r_owp, r_orp;
    logic [sei_pkg::OQAW:0]   r_ocnt;
    logic w_opop;

    assign w_opop = out_if.valid && out_if.ready;
    // room for four results, not counting this cycle's pop
    assign o_pop = i_valid && (r_ocnt <= (sei_pkg::OQAW+1)'(sei_pkg::OQDEPTH - 4));
    assign out_if.valid = (r_ocnt != '0);
    assign out_if.payload = r_oq[r_orp];

    function automatic logic [31:0] sat_add(input logic [31:0] s, input logic [7:0] b);
        logic [32:0] t;
        t = {1'b0, s} + 33'(b);
        sat_add = (t > {1'b0, TOP}) ? TOP : t[31:0];
    endfunction

    // per-byte parse step
    always_comb begin
        logic [7:0] b;
        logic [6:0] w;
        logic [63:0] m, v;
        logic [31:0] idx;
        logic        done;
        b = i_item.data;
        n_ph = r_ph; n_type = r_type; n_size = r_size; n_left = r_left;
        n_gath = r_gath; n_held = r_held; n_ad = r_ad; n_ec = r_ec;
        w_n = 3'd0;
        done = 1'b0;
        w = 7'd0; m = '0; v = '0; idx = '0;
        for (int k = 0; k < 4; k++) w_res[k] = '0;
        if (i_item.keep) begin
            if (r_ph == sei_pkg::PH_TYPE) begin
                n_type = sat_add(r_type, b);
                if (b != sei_pkg::BYTE_EXT) begin
                    w_res[0] = '{sei_pkg::PH_TYPE, 32'd0, {32'd0, n_type}, sei_pkg::ERR_OK, 1'b0};
                    w_n = 3'd1; n_ph = sei_pkg::PH_SIZE;
                end
            end else if (r_ph == sei_pkg::PH_SIZE) begin
                n_size = sat_add(r_size, b);
                if (b != sei_pkg::BYTE_EXT) begin
                    w_res[0] = '{sei_pkg::PH_SIZE, 32'd0, {32'd0, n_size}, sei_pkg::ERR_OK, 1'b0};
                    w_n = 3'd1;
                    unique case (r_type)
                        32'd4: begin
                            if (n_size == 0) begin
                                w_res[1] = '{sei_pkg::PH_WAIT, 32'd0, 64'd0, sei_pkg::ERR_SIZE, 1'b0};
                                w_n = 3'd2; done = 1'b1;
                            end else begin n_left = n_size; n_ph = sei_pkg::PH_CC; end
                        end
                        32'd5: begin
                            if (n_size < 32'd16) begin
                                w_res[1] = '{sei_pkg::PH_WAIT, 32'd0, 64'd0, sei_pkg::ERR_SIZE, 1'b0};
                                w_n = 3'd2; done = 1'b1;
                            end else begin n_left = n_size - 32'd16; n_ph = sei_pkg::PH_UUID_HI; end
                        end
                        32'd137: begin n_ph = sei_pkg::PH_PRIM_X; n_ec = 3'd0; end
                        32'd144: n_ph = sei_pkg::PH_LIGHT;
                        32'd165: n_ph = sei_pkg::PH_ACANCEL;
                        default: begin
                            if (n_size == 0) begin
                                w_res[1] = '{sei_pkg::PH_WAIT, 32'd0, 64'd0, sei_pkg::ERR_SIZE, 1'b0};
                                w_n = 3'd2; done = 1'b1;
                            end else begin n_left = n_size; n_ph = sei_pkg::PH_RAW; end
                        end
                    endcase
                end
            end else if (r_ph == sei_pkg::PH_CC || r_ph == sei_pkg::PH_EXT) begin
                if (r_left == 0) done = 1'b1;
                else begin
                    n_left = r_left - 1;
                    w_res[0] = '{r_ph, 32'd0, {56'd0, b}, sei_pkg::ERR_OK, 1'b0};
                    w_n = 3'd1;
                    if (r_ph == sei_pkg::PH_CC && b == sei_pkg::BYTE_EXT) begin
                        if (n_left == 0) begin
                            w_res[1] = '{sei_pkg::PH_WAIT, 32'd0, 64'd0, sei_pkg::ERR_SIZE, 1'b0};
                            w_n = 3'd2; done = 1'b1;
                        end else n_ph = sei_pkg::PH_EXT;
                    end else begin
                        n_ec = (r_ph == sei_pkg::PH_CC) ? 3'd1 : 3'd2;
                        if (n_left == 0) done = 1'b1; else n_ph = sei_pkg::PH_T35;
                    end
                end
            end else if (r_ph == sei_pkg::PH_T35 || r_ph == sei_pkg::PH_UNREG ||
                         r_ph == sei_pkg::PH_RAW) begin
                if (r_left == 0) done = 1'b1;
                else begin
                    if (r_ph == sei_pkg::PH_T35) idx = r_size - {29'd0, r_ec} - r_left;
                    else if (r_ph == sei_pkg::PH_UNREG) idx = r_size - 32'd16 - r_left;
                    else idx = r_size - r_left;
                    n_left = r_left - 1;
                    w_res[0] = '{r_ph, idx, {56'd0, b}, sei_pkg::ERR_OK, 1'b0};
                    w_n = 3'd1;
                    if (n_left == 0) done = 1'b1;
                end
            end else if (sei_pkg::is_bit_phase(r_ph)) begin
                if (r_held <= 7'd56) begin
                    n_gath = {r_gath[55:0], b};
                    n_held = r_held + 7'd8;
                end
                // at most four fields can complete from one byte
                for (int k = 0; k < 4; k++) begin
                    if (!done && sei_pkg::is_bit_phase(n_ph)) begin
                        w = sei_pkg::field_width(n_ph, n_ad);
                        if (n_held >= w) begin
                            m = (w == 7'd64) ? '1 : ((64'd1 << w) - 64'd1);
                            n_held = n_held - w;
                            v = (n_gath >> n_held) & m;
                            w_res[w_n[1:0]] = '{n_ph,
                                (n_ph == sei_pkg::PH_PRIM_X || n_ph == sei_pkg::PH_PRIM_Y)
                                    ? {29'd0, n_ec} : 32'd0,
                                v, sei_pkg::ERR_OK, 1'b0};
                            w_n = w_n + 3'd1;
                            priority case (n_ph)
                                sei_pkg::PH_UUID_LO: if (n_left == 0) done = 1'b1;
                                                     else n_ph = sei_pkg::PH_UNREG;
                                sei_pkg::PH_PRIM_Y: begin
                                    n_ec = n_ec + 3'd1;
                                    n_ph = (n_ec < 3'd3) ? sei_pkg::PH_PRIM_X
                                                         : sei_pkg::PH_WHITE_X;
                                end
                                sei_pkg::PH_MIN_LUM, sei_pkg::PH_PALL,
                                sei_pkg::PH_CLIPTYP: done = 1'b1;
                                sei_pkg::PH_ACANCEL: if (v != 0) done = 1'b1;
                                                     else n_ph = sei_pkg::PH_USE_IDC;
                                sei_pkg::PH_BDEPTH: begin
                                    n_ad = v[2:0]; n_ph = sei_pkg::PH_TRANSP;
                                end
                                sei_pkg::PH_CLIP: if (v != 0) n_ph = sei_pkg::PH_CLIPTYP;
                                                  else done = 1'b1;
                                default: n_ph = n_ph + 5'd1;
                            endcase
                        end
                    end
                end
            end
        end
        if (done) begin
            n_ph = sei_pkg::PH_WAIT;
            if (w_n != 0) w_res[w_n[1:0] - 2'd1].last = 1'b1;
        end
        if (i_item.eob) begin
            if (n_ph != sei_pkg::PH_WAIT && w_n < 3'd4) begin
                w_res[w_n[1:0]] = '{sei_pkg::PH_WAIT, 32'd0, 64'd0,
                    (n_ph <= sei_pkg::PH_SIZE) ? sei_pkg::ERR_HDR_TRUNC : sei_pkg::ERR_PAY_TRUNC,
                    1'b1};
                w_n = w_n + 3'd1;
            end else if (n_ph != sei_pkg::PH_WAIT && w_n != 0) begin
                w_res[3].last = 1'b1;
            end
            n_ph = sei_pkg::PH_TYPE; n_type = '0; n_size = '0; n_left = '0;
            n_gath = '0; n_held = '0; n_ad = '0; n_ec = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph <= sei_pkg::PH_TYPE; r_type <= '0; r_size <= '0; r_left <= '0;
            r_gath <= '0; r_held <= '0; r_ad <= '0; r_ec <= '0;
        end else if (o_pop) begin
            r_ph <= n_ph; r_type <= n_type; r_size <= n_size; r_left <= n_left;
            r_gath <= n_gath; r_held <= n_held; r_ad <= n_ad; r_ec <= n_ec;
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int k = 0; k < 4; k++)
                if (3'(k) < w_n) r_oq[r_owp + sei_pkg::OQAW'(k)] <= w_res[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp <= '0; r_orp <= '0; r_ocnt <= '0;
        end else begin
            if (o_pop) r_owp <= r_owp + w_n;
            if (w_opop) r_orp <= r_orp + 1'b1;
            r_ocnt <= r_ocnt + (o_pop ? {1'b0, w_n} : 4'd0) - 4'(w_opop);
        end
    end

    `SEI_ASSERT_IMPL(a_oq_bound, i_clk, i_rst_n, 1'b1, r_ocnt <= 4'd8, "result queue overflow")
    `SEI_ASSERT_NEXT(a_eob_reset, i_clk, i_rst_n, o_pop && i_item.eob, r_ph == sei_pkg::PH_TYPE && r_held == 7'd0, "parse state not cleared at buffer end")
    `SEI_ASSERT_IMPL(a_held_bound, i_clk, i_rst_n, 1'b1, r_held <= 7'd64, "bit reader overfull")
endmodule

@@ rtl/hevc_sei_message_parser.sv @@
// SEI message parser. Takes one buffer byte per cycle while the byte queue
// has room and delivers one result per cycle while the receiver is ready,
// via a result queue; a byte yields zero to four results. The front part
// marks emulation-prevention bytes for dropping when stripping is on, feeding
// a four-entry byte queue; the parser stalls only when the eight-entry result
// queue lacks room for four more results, so a burst of results may hold off input.
module hevc_sei_message_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    sei_stream_if.sink   in_if,
    sei_stream_if.source out_if
);
    logic r_strip;
    logic w_push, w_full, w_qvalid, w_pop;
    sei_pkg::t_byte_item w_fitem, w_qitem;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_strip <= 1'b1;
        else if (i_cfg_we) r_strip <= i_cfg_wdata;
    end

    sei_front u_front (
        .i_clk, .i_rst_n, .i_strip(r_strip), .in_if,
        .o_push(w_push), .o_item(w_fitem), .i_full(w_full)
    );

    sei_queue u_queue (
        .i_clk, .i_rst_n, .i_push(w_push), .i_item(w_fitem), .o_full(w_full),
        .i_pop(w_pop), .o_valid(w_qvalid), .o_item(w_qitem)
    );

    sei_parser u_parser (
        .i_clk, .i_rst_n, .i_valid(w_qvalid), .i_item(w_qitem),
        .o_pop(w_pop), .out_if
    );
endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps

module tb;
    import sei_pkg::*;

    // Payload types with a dedicated parse path
    localparam logic [31:0] TYPE_T35   = 32'd4;
    localparam logic [31:0] TYPE_UNREG = 32'd5;
    localparam logic [31:0] TYPE_MDCV  = 32'd137;
    localparam logic [31:0] TYPE_CLL   = 32'd144;
    localparam logic [31:0] TYPE_ALPHA = 32'd165;

    // Field codes under local names; code 21 has no name in the package
    localparam logic [4:0] FC_WHITE_X  = 5'd10;
    localparam logic [4:0] FC_WHITE_Y  = 5'd11;
    localparam logic [4:0] FC_MAX_LUM  = 5'd12;
    localparam logic [4:0] FC_USE_IDC  = 5'd17;
    localparam logic [4:0] FC_TRANSP   = 5'd19;
    localparam logic [4:0] FC_INCR     = 5'd21;

    localparam int UUID_BYTES    = 16;
    localparam int MAX_PER_BYTE  = 4;
    localparam int IDLE_LIMIT    = 5000;
    localparam int DRAIN_CYCLES  = 12;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;

    sei_stream_if #(.W(9))               in_if ();
    sei_stream_if #(.W($bits(t_result))) out_if ();

    hevc_sei_message_parser u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .in_if       (in_if),
        .out_if      (out_if)
    );

    // Parser state mirror
    bit          strip_epb;
    logic [4:0]  phase;
    logic [1:0]  zeros_seen;
    logic [31:0] type_acc;
    logic [31:0] size_acc;
    logic [31:0] data_left;
    logic [63:0] gather;
    int unsigned gather_bits;
    logic [2:0]  alpha_bd;
    logic [2:0]  elem_cnt;
    int          step_results;

    t_result expected_fields[$];

    int errors;
    int mismatches;
    int bytes_sent;
    int results_seen;
    int messages_sent;
    int idle_cycles;
    int burst_left;
    int ready_pct;
    int ready_hold;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic void clear_parser();
        phase       = PH_TYPE;
        zeros_seen  = '0;
        type_acc    = '0;
        size_acc    = '0;
        data_left   = '0;
        gather      = '0;
        gather_bits = 0;
        alpha_bd    = '0;
        elem_cnt    = '0;
    endfunction

    function automatic logic [31:0] acc_sat(input logic [31:0] s, input logic [7:0] b);
        logic [32:0] t;
        t = {1'b0, s} + {25'd0, b};
        return t[32] ? 32'hffff_ffff : t[31:0];
    endfunction

    function automatic void push_field(input logic [4:0] code, input logic [31:0] idx,
                                       input logic [63:0] val, input logic [1:0] err);
        t_result r;
        if (step_results >= MAX_PER_BYTE) return;
        r.code  = code;
        r.index = idx;
        r.value = val;
        r.err   = err;
        r.last  = 1'b0;
        expected_fields.push_back(r);
        step_results++;
    endfunction

    function automatic void end_message();
        if (step_results > 0) expected_fields[expected_fields.size() - 1].last = 1'b1;
        phase = PH_WAIT;
    endfunction

    function automatic void abort_message(input logic [1:0] err);
        push_field(PH_WAIT, '0, '0, err);
        end_message();
    endfunction

    function automatic void pick_payload_path();
        case (type_acc)
            TYPE_T35: begin
                if (size_acc == 0) begin abort_message(ERR_SIZE); return; end
                data_left = size_acc;
                phase = PH_CC;
            end
            TYPE_UNREG: begin
                if (size_acc < UUID_BYTES) begin abort_message(ERR_SIZE); return; end
                data_left = size_acc - UUID_BYTES;
                phase = PH_UUID_HI;
            end
            TYPE_MDCV: begin phase = PH_PRIM_X; elem_cnt = '0; end
            TYPE_CLL:   phase = PH_LIGHT;
            TYPE_ALPHA: phase = PH_ACANCEL;
            default: begin
                if (size_acc == 0) begin abort_message(ERR_SIZE); return; end
                data_left = size_acc;
                phase = PH_RAW;
            end
        endcase
    endfunction

    function automatic int unsigned bits_of(input logic [4:0] ph);
        if (ph == PH_UUID_HI || ph == PH_UUID_LO) return 64;
        if (ph == FC_MAX_LUM || ph == PH_MIN_LUM) return 32;
        if ((ph >= PH_PRIM_X && ph <= FC_WHITE_Y) || ph == PH_LIGHT || ph == PH_PALL)
            return 16;
        if (ph == FC_USE_IDC || ph == PH_BDEPTH) return 3;
        if (ph == FC_TRANSP || ph == PH_OPAQUE) return alpha_bd + 9;
        return 1;
    endfunction

    function automatic bit bit_field_phase(input logic [4:0] ph);
        return ph == PH_UUID_HI || ph == PH_UUID_LO || (ph >= PH_PRIM_X && ph <= PH_CLIPTYP);
    endfunction

    function automatic void store_field(input logic [63:0] v);
        logic [4:0] ph;
        ph = phase;
        push_field(ph, (ph == PH_PRIM_X || ph == PH_PRIM_Y) ? {29'd0, elem_cnt} : 32'd0,
                   v, ERR_OK);
        case (ph)
            PH_UUID_LO: if (data_left == 0) end_message(); else phase = PH_UNREG;
            PH_PRIM_Y: begin
                elem_cnt = elem_cnt + 3'd1;
                phase = (elem_cnt < 3) ? PH_PRIM_X : FC_WHITE_X;
            end
            PH_MIN_LUM, PH_PALL, PH_CLIPTYP: end_message();
            PH_ACANCEL: if (v != 0) end_message(); else phase = FC_USE_IDC;
            PH_BDEPTH: begin
                alpha_bd = v[2:0];
                phase = FC_TRANSP;
            end
            PH_CLIP: if (v != 0) phase = PH_CLIPTYP; else end_message();
            default: phase = ph + 5'd1;
        endcase
    endfunction

    function automatic void feed_bits(input logic [7:0] b);
        int unsigned w;
        logic [63:0] m;
        if (gather_bits <= 56) begin
            gather = (gather << 8) | {56'd0, b};
            gather_bits += 8;
        end
        while (bit_field_phase(phase)) begin
            w = bits_of(phase);
            m = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
            if (gather_bits < w) break;
            gather_bits -= w;
            store_field((gather >> gather_bits) & m);
        end
    endfunction

    function automatic void payload_byte(input logic [4:0] ph, input logic [7:0] b);
        logic [31:0] idx;
        if (data_left == 0) begin end_message(); return; end
        if (ph == PH_T35) idx = size_acc - {29'd0, elem_cnt} - data_left;
        else if (ph == PH_UNREG) idx = size_acc - UUID_BYTES - data_left;
        else idx = size_acc - data_left;
        data_left--;
        push_field(ph, idx, {56'd0, b}, ERR_OK);
        if (data_left == 0) end_message();
    endfunction

    function automatic void parse_byte(input logic [7:0] b);
        logic [4:0] ph;
        ph = phase;
        if (ph == PH_TYPE) begin
            type_acc = acc_sat(type_acc, b);
            if (b != BYTE_EXT) begin
                push_field(PH_TYPE, '0, {32'd0, type_acc}, ERR_OK);
                phase = PH_SIZE;
            end
        end else if (ph == PH_SIZE) begin
            size_acc = acc_sat(size_acc, b);
            if (b != BYTE_EXT) begin
                push_field(PH_SIZE, '0, {32'd0, size_acc}, ERR_OK);
                pick_payload_path();
            end
        end else if (ph == PH_CC) begin
            if (data_left == 0) begin end_message(); return; end
            data_left--;
            push_field(PH_CC, '0, {56'd0, b}, ERR_OK);
            if (b == BYTE_EXT) begin
                if (data_left == 0) abort_message(ERR_SIZE); else phase = PH_EXT;
            end else begin
                elem_cnt = 3'd1;
                if (data_left == 0) end_message(); else phase = PH_T35;
            end
        end else if (ph == PH_EXT) begin
            if (data_left == 0) begin end_message(); return; end
            data_left--;
            push_field(PH_EXT, '0, {56'd0, b}, ERR_OK);
            elem_cnt = 3'd2;
            if (data_left == 0) end_message(); else phase = PH_T35;
        end else if (ph == PH_T35 || ph == PH_UNREG || ph == PH_RAW) begin
            payload_byte(ph, b);
        end else if (bit_field_phase(ph)) begin
            feed_bits(b);
        end
    endfunction

    function automatic void predict_byte(input logic [7:0] b, input bit eob);
        step_results = 0;
        if (strip_epb && zeros_seen >= 2 && b == BYTE_EPB) begin
            zeros_seen = '0;
        end else begin
            if (b == 0) zeros_seen = (zeros_seen < 2) ? zeros_seen + 2'd1 : 2'd2;
            else zeros_seen = '0;
            parse_byte(b);
        end
        if (eob) begin
            if (phase != PH_WAIT)
                abort_message((phase <= PH_SIZE) ? ERR_HDR_TRUNC : ERR_PAY_TRUNC);
            clear_parser();
        end
    endfunction

    // ---------------- result checker and receiver stalls ----------------
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
            ready_hold   <= 0;
            ready_pct    <= 100;
        end else begin
            if (out_if.valid && out_if.ready) begin
                got = t_result'(out_if.payload);
                results_seen++;
                if (expected_fields.size() == 0) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result code=%0d idx=%0d val=%h err=%0d last=%0b",
                                 $realtime, got.code, got.index, got.value, got.err, got.last);
                end else begin
                    want = expected_fields.pop_front();
                    if (got !== want) begin
                        errors++;
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: mismatch exp code=%0d idx=%0d val=%h err=%0d last=%0b",
                                     $realtime, want.code, want.index, want.value, want.err,
                                     want.last,
                                     " / got code=%0d idx=%0d val=%h err=%0d last=%0b",
                                     got.code, got.index, got.value, got.err, got.last);
                    end
                end
            end
            // stall pattern: regimes of varying ready density
            if (ready_hold == 0) begin
                ready_pct  <= ($urandom_range(0, 3) == 0) ? 100 : $urandom_range(20, 95);
                ready_hold <= $urandom_range(10, 60);
            end else begin
                ready_hold <= ready_hold - 1;
            end
            out_if.ready <= ($urandom_range(1, 100) <= ready_pct);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------- stimulus helpers ----------------
    task automatic send_byte(input logic [7:0] b, input bit eob);
        int gap;
        in_if.valid   <= 1'b1;
        in_if.payload <= {eob, b};
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        predict_byte(b, eob);
        bytes_sent++;
        // bursty sender
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic send_buffer(input logic [7:0] bytes_q[$]);
        foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
        messages_sent++;
    endtask

    task automatic wait_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_fields.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_strip(input bit v);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        strip_epb = v;
    endtask

    function automatic logic [7:0] rnd_byte();
        case ($urandom_range(0, 7))
            0, 1: return 8'h00;
            2:    return BYTE_EPB;
            3:    return BYTE_EXT;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Well-formed message of random kind, sometimes cut short or padded
    task automatic make_message(output logic [7:0] q[$]);
        int kind;
        int sz;
        int body;
        int cut;
        q = {};
        kind = $urandom_range(0, 7);
        case (kind)
            0: begin sz = $urandom_range(1, 6); q.push_back(8'd4); end
            1: begin sz = $urandom_range(16, 20); q.push_back(8'd5); end
            2: begin sz = 24; q.push_back(8'd137); end
            3: begin sz = 4; q.push_back(8'd144); end
            4: begin sz = $urandom_range(1, 7); q.push_back(8'd165); end
            5: begin
                sz = $urandom_range(1, 5);
                q.push_back(BYTE_EXT);
                q.push_back(8'($urandom_range(0, 254)));
            end
            default: begin
                sz = $urandom_range(0, 6);
                q.push_back(8'($urandom_range(0, 254)));
            end
        endcase
        q.push_back(8'(sz));
        body = sz;
        if (kind == 0 && $urandom_range(0, 2) == 0) begin
            q.push_back(BYTE_EXT);
            body = sz - 1;
        end
        if (kind == 4 && $urandom_range(0, 3) == 0) q.push_back(8'h80);
        for (int i = 0; i < body; i++) q.push_back(rnd_byte());
        if ($urandom_range(0, 5) == 0) begin
            cut = $urandom_range(1, q.size());
            while (q.size() > cut) void'(q.pop_back());
        end
        if ($urandom_range(0, 4) == 0)
            repeat ($urandom_range(1, 3)) q.push_back(rnd_byte());
    endtask

    // ---------------- tests ----------------
    task automatic test_known_types();
        send_buffer('{8'd4, 8'd5, 8'hb5, 8'h00, 8'hff, 8'h00});
        send_buffer('{8'd4, 8'd3, 8'hff, 8'h7e, 8'h01});
        send_buffer('{8'd5, 8'd17, 8'h01, 8'h23, 8'h45, 8'h67, 8'h89, 8'hab, 8'hcd, 8'hef,
                      8'hfe, 8'hdc, 8'hba, 8'h98, 8'h76, 8'h54, 8'h32, 8'h10, 8'h5a});
        send_buffer('{8'd144, 8'd4, 8'hff, 8'hff, 8'h00, 8'h01});
        send_buffer('{8'd165, 8'd1, 8'h80});
        send_buffer('{8'd165, 8'd6, 8'h7f, 8'hff, 8'hff, 8'hff, 8'hff, 8'hfc, 8'h11});
        send_buffer('{8'hff, 8'd2, 8'd2, 8'h00, 8'hff, 8'h44});
    endtask

    task automatic test_mastering_display();
        logic [7:0] q[$];
        q = '{8'd137, 8'd24};
        for (int i = 0; i < 24; i++) q.push_back(8'($urandom_range(0, 255)));
        send_buffer(q);
    endtask

    task automatic test_size_and_truncation();
        send_buffer('{8'd4, 8'd0});
        send_buffer('{8'd4, 8'd1, 8'hff});
        send_buffer('{8'd5, 8'd15, 8'h00});
        send_buffer('{8'd9, 8'd0});
        send_buffer('{8'hff});
        send_buffer('{8'd7, 8'hff});
        send_buffer('{8'd7, 8'd4, 8'h01, 8'h02});
        send_buffer('{8'd144, 8'd4, 8'h12});
    endtask

    task automatic test_emulation(input bit strip);
        write_strip(strip);
        send_buffer('{8'd6, 8'd4, 8'h00, 8'h00, 8'h03, 8'h01, 8'h00, 8'h00});
        send_buffer('{8'd6, 8'd2, 8'h00, 8'h00, 8'h03});
    endtask

    task automatic test_random(input int target_bytes, input bit with_pause);
        logic [7:0] q[$];
        int stop_at;
        bit paused;
        stop_at = bytes_sent + target_bytes;
        paused = 0;
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 9) == 0) begin
                q = {};
                repeat ($urandom_range(1, 5)) q.push_back(rnd_byte());
            end else begin
                make_message(q);
            end
            send_buffer(q);
            if (with_pause && !paused && bytes_sent > stop_at - target_bytes / 2) begin
                wait_drained();
                paused = 1;
            end
        end
    endtask

    // ---------------- main sequence ----------------
    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = 1'b0;
        in_if.valid   = 1'b0;
        in_if.payload = '0;
        bytes_sent = 0;
        messages_sent = 0; burst_left = 0;
        strip_epb = 1'b1;
        clear_parser();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_known_types();
        test_mastering_display();
        test_size_and_truncation();
        test_emulation(1'b1);
        test_emulation(1'b0);
        test_random(65, 1'b1);
        write_strip(1'b1);
        test_random(65, 1'b0);
        write_strip(1'b0);
        test_random(45, 1'b0);

        wait_drained();
        $display("Parsed %0d buffers (%0d bytes), checked %0d fields across all payload kinds,",
                 messages_sent, bytes_sent, results_seen);
        $display("error paths and both emulation-byte settings; %0d mismatches.", mismatches);
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
